FILE: rtl/tcgr_pkg.sv
// Shared types, codes and constants of the text console glyph renderer.
package tcgr_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_WORDS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLUMNS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ROWS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_MODE   = 2'd3;

    localparam logic [14:0] PITCH_RESET   = 15'd1024;
    localparam logic [7:0]  COLUMNS_RESET = 8'd128;
    localparam logic [6:0]  ROWS_RESET    = 7'd48;
    localparam logic        MODE_RESET    = 1'b0;
    localparam logic        MODE_16BPP    = 1'b1;

    // Input commands and result kinds
    localparam logic CMD_PRINT   = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;
    localparam logic KIND_GLYPH  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Console character codes
    localparam logic [7:0] CH_ESCAPE      = 8'h01;
    localparam logic [7:0] CH_NEWLINE     = 8'h0A;
    localparam logic [7:0] CH_LAST_COLOUR = 8'h0F;
    localparam logic [7:0] CH_BOLD_OFF    = 8'h10;
    localparam logic [7:0] CH_BOLD_ON     = 8'h11;

    localparam logic [3:0] FG_RESET = 4'hF;

    // Operations queued from front to back
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_GLYPH  = 2'd1;
    localparam logic [1:0] OP_SCROLL = 2'd2;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct packed {
        logic [14:0] pitch_words;
        logic [7:0]  text_columns;
        logic [6:0]  text_rows;
        logic        pixel_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        bold;
        logic [7:0]  glyph;
        logic [3:0]  line;
        logic [7:0]  bits;
        logic [6:0]  row;
        logic [7:0]  col;
        logic [23:0] colour;
        logic        scroll;
    } cmd_t;

    typedef struct packed {
        logic                   kind;
        logic [OFFSET_BITS-1:0] word_offset;
        logic [7:0]             pixel_mask;
        logic [23:0]            colour;
        logic                   last;
    } res_t;

    function automatic logic [23:0] to_rgb565(input logic [23:0] c);
        return {8'h00, c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

FILE: rtl/tcgr_fifo.sv
// Small register queue used for the command queue and the result queue.
module tcgr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

FILE: rtl/tcgr_front.sv
// Front end: accept items, track cursor, colour, bold and escape, queue work.
module tcgr_front #(
    parameter int GLYPH_LINES = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tcgr_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic          cmd,
    input  logic [7:0]    char_code,
    input  logic          font_is_bold,
    input  logic [3:0]    font_row,
    input  logic [7:0]    font_bits,
    output logic          enq,
    output tcgr_pkg::cmd_t enq_cmd
);
    import tcgr_pkg::*;

    logic [7:0]  col_reg, col_next;
    logic [6:0]  row_reg, row_next;
    logic [3:0]  fg_reg, fg_next;
    logic        bold_reg, bold_next;
    logic        esc_reg, esc_next;

    logic [7:0]  cols;
    logic [6:0]  rows;
    logic [7:0]  glyph;
    logic [7:0]  col_inc;
    logic        nl_scroll;
    logic [6:0]  nl_row;
    logic [23:0] rgb;
    logic        want;

    always_comb
    begin
        cols      = (cfg.text_columns == '0) ? 8'd1 : cfg.text_columns;
        rows      = (cfg.text_rows == '0) ? 7'd1 : cfg.text_rows;
        glyph     = ({1'b0, char_code} >= 9'(GLYPH_COUNT))
                    ? 8'({1'b0, char_code} - 9'(GLYPH_COUNT)) : char_code;
        col_inc   = col_reg + 8'd1;
        nl_scroll = (row_reg >= rows - 7'd1);
        nl_row    = nl_scroll ? rows - 7'd1 : row_reg + 7'd1;
        rgb       = PALETTE[fg_reg];

        col_next  = col_reg;
        row_next  = row_reg;
        fg_next   = fg_reg;
        bold_next = bold_reg;
        esc_next  = esc_reg;
        want      = 1'b0;

        enq_cmd.op     = OP_GLYPH;
        enq_cmd.bold   = (cmd == CMD_LOAD) ? font_is_bold : bold_reg;
        enq_cmd.glyph  = glyph;
        enq_cmd.line   = font_row;
        enq_cmd.bits   = font_bits;
        enq_cmd.row    = row_reg;
        enq_cmd.col    = col_reg;
        enq_cmd.colour = (cfg.pixel_mode == MODE_16BPP) ? to_rgb565(rgb) : rgb;
        enq_cmd.scroll = 1'b0;

        if (cmd == CMD_LOAD)
        begin
            // drop lines beyond the glyph height
            if (6'(font_row) < 6'(GLYPH_LINES))
            begin
                want       = 1'b1;
                enq_cmd.op = OP_LOAD;
            end
        end
        else if (char_code == CH_NEWLINE)
        begin
            col_next = '0;
            row_next = nl_row;
            if (nl_scroll)
            begin
                want       = 1'b1;
                enq_cmd.op = OP_SCROLL;
            end
        end
        else if (char_code == CH_ESCAPE)
        begin
            esc_next = 1'b1;
        end
        else if (esc_reg)
        begin
            if (char_code <= CH_LAST_COLOUR)
            begin
                fg_next = char_code[3:0];
            end
            else if (char_code == CH_BOLD_OFF || char_code == CH_BOLD_ON)
            begin
                bold_next = (char_code == CH_BOLD_ON);
            end
            esc_next = 1'b0;
        end
        else
        begin
            want     = 1'b1;
            col_next = col_inc;
            if (col_inc == '0 || col_inc >= cols)
            begin
                col_next       = '0;
                row_next       = nl_row;
                enq_cmd.scroll = nl_scroll;
            end
        end

        enq = accept && want;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            fg_reg   <= FG_RESET;
            bold_reg <= 1'b0;
            esc_reg  <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            fg_reg   <= fg_next;
            bold_reg <= bold_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

FILE: rtl/tcgr_back.sv
// Back end: font memory, glyph line sequencer and result queue.
module tcgr_back #(
    parameter int GLYPH_LINES = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tcgr_pkg::cfg_t cfg,
    input  logic           cmd_empty,
    input  tcgr_pkg::cmd_t cmd_head,
    output logic           cmd_pop,
    input  logic           res_pop,
    output logic           res_empty,
    output tcgr_pkg::res_t res_head
);
    import tcgr_pkg::*;

    localparam int FONT_DEPTH = 2 * GLYPH_COUNT * GLYPH_LINES;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int LINE_W     = $clog2(GLYPH_LINES);
    localparam int ROWL_W     = 7 + $clog2(GLYPH_LINES);
    localparam int PROD_W     = 15 + ROWL_W;
    localparam int RES_DEPTH  = 4;
    localparam int RES_CW     = $clog2(RES_DEPTH+1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_LINES  = 2'd2;
    localparam logic [1:0] ST_SCROLL = 2'd3;

    logic [7:0] font_mem [FONT_DEPTH];
    logic [7:0] mem_q_reg;

    logic [1:0]             state_reg, state_next;
    logic [LINE_W-1:0]      line_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [FONT_AW-1:0]     fbase_reg;
    logic [ROWL_W-1:0]      rowl_reg;
    logic [7:0]             col_reg;
    logic [23:0]            colour_reg;
    logic                   scroll_reg;

    logic                   s1_valid_reg;
    logic                   s1_kind_reg;
    logic [OFFSET_BITS-1:0] s1_off_reg;
    logic [23:0]            s1_colour_reg;
    logic                   s1_last_reg;

    logic [FONT_AW-1:0]     head_base;
    logic [FONT_AW-1:0]     load_addr;
    logic [FONT_AW-1:0]     rd_addr;
    logic                   mem_we;
    logic                   can_issue;
    logic                   issue_line;
    logic                   issue_scroll;
    logic                   line_last;
    logic [PROD_W-1:0]      row_prod;
    logic [10:0]            col_words;
    logic [OFFSET_BITS-1:0] setup_off;

    res_t                   res_in;
    logic                   res_full;
    logic [RES_CW-1:0]      res_count;

    always_comb
    begin
        head_base = FONT_AW'((32'(cmd_head.bold) * GLYPH_COUNT + 32'(cmd_head.glyph))
                             * GLYPH_LINES);
        load_addr = head_base + FONT_AW'(cmd_head.line);
        rd_addr   = fbase_reg + FONT_AW'(line_reg);
        cmd_pop   = (state_reg == ST_IDLE) && !cmd_empty;
        mem_we    = cmd_pop && (cmd_head.op == OP_LOAD);

        // keep room for the item already in flight to the result queue
        can_issue    = (32'(res_count) + 32'(s1_valid_reg)) < RES_DEPTH;
        issue_line   = (state_reg == ST_LINES) && can_issue;
        issue_scroll = (state_reg == ST_SCROLL) && can_issue;
        line_last    = (line_reg == LINE_W'(GLYPH_LINES-1));

        row_prod  = PROD_W'(cfg.pitch_words) * PROD_W'(rowl_reg);
        col_words = (cfg.pixel_mode == MODE_16BPP) ? {1'b0, col_reg, 2'b00}
                                                   : {col_reg, 3'b000};
        setup_off = OFFSET_BITS'(row_prod) + OFFSET_BITS'(col_words);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    if (cmd_head.op == OP_GLYPH)
                    begin
                        state_next = ST_SETUP;
                    end
                    else if (cmd_head.op == OP_SCROLL)
                    begin
                        state_next = ST_SCROLL;
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_LINES;
            end
            ST_LINES:
            begin
                if (issue_line && line_last)
                begin
                    state_next = scroll_reg ? ST_SCROLL : ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                if (issue_scroll)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_in.kind        = s1_kind_reg;
        res_in.word_offset = s1_off_reg;
        res_in.pixel_mask  = (s1_kind_reg == KIND_SCROLL) ? 8'h00 : mem_q_reg;
        res_in.colour      = s1_colour_reg;
        res_in.last        = s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[load_addr] <= cmd_head.bits;
        end
        if (issue_line)
        begin
            mem_q_reg <= font_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            line_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue_line || issue_scroll;
            if (state_reg == ST_SETUP)
            begin
                line_reg <= '0;
            end
            else if (issue_line)
            begin
                line_reg <= line_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            fbase_reg  <= head_base;
            rowl_reg   <= ROWL_W'(32'(cmd_head.row) * GLYPH_LINES);
            col_reg    <= cmd_head.col;
            colour_reg <= cmd_head.colour;
            scroll_reg <= cmd_head.scroll;
        end
        if (state_reg == ST_SETUP)
        begin
            off_reg <= setup_off;
        end
        else if (issue_line)
        begin
            off_reg <= off_reg + OFFSET_BITS'(cfg.pitch_words);
        end
        if (issue_line)
        begin
            s1_kind_reg   <= KIND_GLYPH;
            s1_off_reg    <= off_reg;
            s1_colour_reg <= colour_reg;
            s1_last_reg   <= line_last && !scroll_reg;
        end
        else if (issue_scroll)
        begin
            s1_kind_reg   <= KIND_SCROLL;
            s1_off_reg    <= '0;
            s1_colour_reg <= '0;
            s1_last_reg   <= 1'b1;
        end
    end

    tcgr_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s1_valid_reg),
        .wr_data (res_in),
        .pop     (res_pop),
        .rd_data (res_head),
        .full    (res_full),
        .empty   (res_empty),
        .count   (res_count)
    );

    // the credit check above keeps the result queue from overflowing
    logic unused_full;
    assign unused_full = res_full;

endmodule

FILE: rtl/text_console_glyph_renderer_core.sv
// Top level of the text console glyph renderer: ports, registers, front and back.
//
// Draws console text into a linear framebuffer as a stream of glyph-row writes.
// Each input item either loads one line of the regular or bold font, or presents
// one console character; 0x01 opens an escape (0x00-0x0F picks the palette colour,
// 0x10/0x11 turn bold off/on), a newline moves the cursor and on the last row
// emits a scroll-up item, and any other character emits GLYPH_LINES row writes
// (word offset, 8-pixel mask, colour) followed by a scroll item when the cursor
// wraps past the last row. The font memory has no defined contents after reset:
// load every glyph line before printing it. There is no clearing pass; the block
// accepts items from the first cycle after reset. Timing: the front end takes
// one item per cycle into a four-entry command queue, and full rises only when
// that queue is full. The back end is the bottleneck: a font load is written as
// its command is popped, a scrolling newline pops and then issues a scroll item,
// and a printed character pops the command, forms the start offset with the
// pitch multiply, then makes one font memory read per glyph line, and adds a
// scroll item when it causes a scroll. The result queue holds four items, and
// the line sequencer stops issuing when queued plus in-flight items reach four.
// Write configuration registers only while the block is idle.
module text_console_glyph_renderer_core #(
    parameter int GLYPH_LINES = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [tcgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]      cfg_data,

    // input items
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 cmd,
    input  logic [7:0]                           char_code,
    input  logic                                 font_is_bold,
    input  logic [3:0]                           font_row,
    input  logic [7:0]                           font_bits,

    // result items
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 kind,
    output logic [tcgr_pkg::OFFSET_BITS-1:0]     word_offset,
    output logic [7:0]                           pixel_mask,
    output logic [23:0]                          colour,
    output logic                                 last
);
    import tcgr_pkg::*;

    localparam int CMD_DEPTH = 4;

    cfg_t cfg_reg;

    logic       accept;
    logic       enq;
    cmd_t       enq_cmd;
    cmd_t       cmd_head;
    logic       cmd_empty;
    logic       cmd_full;
    logic       cmd_pop;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    logic       res_empty;
    res_t       res_head;

    // Configuration registers: take the write in the same cycle, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_words  <= PITCH_RESET;
            cfg_reg.text_columns <= COLUMNS_RESET;
            cfg_reg.text_rows    <= ROWS_RESET;
            cfg_reg.pixel_mode   <= MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PITCH_WORDS:  cfg_reg.pitch_words  <= cfg_data;
                REG_TEXT_COLUMNS: cfg_reg.text_columns <= cfg_data[7:0];
                REG_TEXT_ROWS:    cfg_reg.text_rows    <= cfg_data[6:0];
                REG_PIXEL_MODE:   cfg_reg.pixel_mode   <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Hold off input while the command queue has no free entry, even for
    // items that would not queue anything.
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    tcgr_front #(
        .GLYPH_LINES (GLYPH_LINES),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .cmd          (cmd),
        .char_code    (char_code),
        .font_is_bold (font_is_bold),
        .font_row     (font_row),
        .font_bits    (font_bits),
        .enq          (enq),
        .enq_cmd      (enq_cmd)
    );

    // Command queue between classification and rendering.
    tcgr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (enq),
        .wr_data (enq_cmd),
        .pop     (cmd_pop),
        .rd_data (cmd_head),
        .full    (cmd_full),
        .empty   (cmd_empty),
        .count   (cmd_count)
    );

    // Occupancy is not needed on this side; full and empty cover the handshake.
    logic unused_count;
    assign unused_count = ^cmd_count;

    tcgr_back #(
        .GLYPH_LINES (GLYPH_LINES),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_pop   (pop && !res_empty),
        .res_empty (res_empty),
        .res_head  (res_head)
    );

    // Present the oldest waiting result item.
    assign empty       = res_empty;
    assign kind        = res_head.kind;
    assign word_offset = res_head.word_offset;
    assign pixel_mask  = res_head.pixel_mask;
    assign colour      = res_head.colour;
    assign last        = res_head.last;

endmodule

FILE: tb/sv/text_console_glyph_renderer_core_tb.sv
// Self-checking testbench for the text console glyph renderer core.
`timescale 1ns / 100ps

module text_console_glyph_renderer_core_tb;

    import tcgr_pkg::*;

    // Glyph geometry of the instance under test
    localparam int LINES       = 16;
    localparam int FONT_WORDS  = 2 * 256 * LINES;
    // Input items offered over the whole run
    localparam int TOTAL_ITEMS = 370;
    // Cycles to let pass after the last expected result before touching registers:
    // four queued commands plus a full character, with margin
    localparam int IDLE_WAIT   = 40;
    // Upper bound on a drain, in cycles, so leftovers get reported instead of hanging
    localparam int DRAIN_BOUND = 20000;
    // Long receiver hold-off that forces the block to back up and raise full
    localparam int HOLD_CYCLES = 400;

    // 16-entry console palette, RGB888
    localparam logic [23:0] SHADES [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    // Mirror of the console state: font memory, cursor, colour and escape flags,
    // plus the glyph-row writes and scrolls still owed by the block.
    class render_tracker;
        logic [14:0] pitch;
        logic [7:0]  columns;
        logic [6:0]  rows;
        logic        mode16;
        logic [7:0]  font [0:FONT_WORDS-1];
        bit          written [0:FONT_WORDS-1];
        logic [7:0]  cur_col;
        logic [6:0]  cur_row;
        logic [3:0]  fg;
        bit          bold;
        bit          esc;
        res_t        due_writes [$];
        int          errors;

        function new();
            pitch   = PITCH_RESET;
            columns = COLUMNS_RESET;
            rows    = ROWS_RESET;
            mode16  = MODE_RESET;
            cur_col = 8'd0;
            cur_row = 7'd0;
            fg      = FG_RESET;
            bold    = 1'b0;
            esc     = 1'b0;
            errors  = 0;
            for (int i = 0; i < FONT_WORDS; i++)
            begin
                font[i]    = 8'd0;
                written[i] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PITCH_WORDS:  pitch   = data;
                REG_TEXT_COLUMNS: columns = data[7:0];
                REG_TEXT_ROWS:    rows    = data[6:0];
                REG_PIXEL_MODE:   mode16  = data[0];
                default: ;
            endcase
        endfunction

        // True when every line of glyph g in the given font has been loaded
        function bit glyph_ready(bit b, logic [7:0] g);
            for (int y = 0; y < LINES; y++)
            begin
                if (!written[{b, g, 4'(y)}])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void queue_write(logic k, logic [23:0] off, logic [7:0] m,
                                  logic [23:0] c, logic l);
            res_t w;
            w.kind        = k;
            w.word_offset = off;
            w.pixel_mask  = m;
            w.colour      = c;
            w.last        = l;
            due_writes.push_back(w);
        endfunction

        // Carriage return plus line feed; returns 1 when the screen must scroll
        function bit line_feed();
            logic [6:0] bottom;
            bottom  = (rows == 7'd0) ? 7'd0 : 7'(rows - 7'd1);
            cur_col = 8'd0;
            if (cur_row >= bottom)
            begin
                cur_row = bottom;
                return 1'b1;
            end
            cur_row = 7'(cur_row + 7'd1);
            return 1'b0;
        endfunction

        function logic [23:0] pack565(logic [23:0] c);
            logic [4:0] r5;
            logic [5:0] g6;
            logic [4:0] b5;
            r5 = 5'(c[23:16] >> 3);
            g6 = 6'(c[15:8] >> 2);
            b5 = 5'(c[7:0] >> 3);
            return {8'd0, r5, g6, b5};
        endfunction

        // Emit the row writes of one printed character and advance the cursor
        function void draw_char(logic [7:0] ch);
            logic [23:0] shade;
            logic [31:0] base;
            logic [31:0] off;
            logic [7:0]  cols;
            bit          wrap;
            shade = mode16 ? pack565(SHADES[fg]) : SHADES[fg];
            base  = 32'(pitch) * 32'd16 * 32'(cur_row)
                  + 32'(cur_col) * (mode16 ? 32'd4 : 32'd8);
            cols  = (columns == 8'd0) ? 8'd1 : columns;
            cur_col = 8'(cur_col + 8'd1);
            wrap  = 1'b0;
            if (cur_col == 8'd0 || cur_col >= cols)
                wrap = line_feed();
            for (int y = 0; y < LINES; y++)
            begin
                off = base + 32'(y) * 32'(pitch);
                queue_write(KIND_GLYPH, off[23:0], font[{bold, ch, 4'(y)}], shade,
                            !wrap && (y == LINES - 1));
            end
            if (wrap)
                queue_write(KIND_SCROLL, 24'd0, 8'd0, 24'd0, 1'b1);
        endfunction

        function void take_item(logic c, logic [7:0] ch, logic fb, logic [3:0] fr,
                                logic [7:0] bits);
            if (c == CMD_LOAD)
            begin
                font[{fb, ch, fr}]    = bits;
                written[{fb, ch, fr}] = 1'b1;
                return;
            end
            // a newline runs even inside an escape and leaves it pending
            if (ch == CH_NEWLINE)
            begin
                if (line_feed())
                    queue_write(KIND_SCROLL, 24'd0, 8'd0, 24'd0, 1'b1);
                return;
            end
            if (ch == CH_ESCAPE)
            begin
                esc = 1'b1;
                return;
            end
            if (esc)
            begin
                if (ch <= CH_LAST_COLOUR)
                    fg = ch[3:0];
                else if (ch == CH_BOLD_OFF || ch == CH_BOLD_ON)
                    bold = (ch == CH_BOLD_ON);
                esc = 1'b0;
                return;
            end
            draw_char(ch);
        endfunction

        function void match_write(res_t got);
            res_t want;
            if (due_writes.size() == 0)
            begin
                $error("unexpected result: kind %0d offset %0h mask %0h colour %0h last %0d",
                       got.kind, got.word_offset, got.pixel_mask, got.colour, got.last);
                errors++;
                return;
            end
            want = due_writes.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.word_offset !== want.word_offset)
            begin
                $error("word_offset: expected %0h, actual %0h",
                       want.word_offset, got.word_offset);
                errors++;
            end
            if (got.pixel_mask !== want.pixel_mask)
            begin
                $error("pixel_mask: expected %0h, actual %0h", want.pixel_mask, got.pixel_mask);
                errors++;
            end
            if (got.colour !== want.colour)
            begin
                $error("colour: expected %0h, actual %0h", want.colour, got.colour);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // Block ports; every input holds a known value from time zero
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   push         = 1'b0;
    logic                   full;
    logic                   cmd          = 1'b0;
    logic [7:0]             char_code    = 8'd0;
    logic                   font_is_bold = 1'b0;
    logic [3:0]             font_row     = 4'd0;
    logic [7:0]             font_bits    = 8'd0;
    logic                   empty;
    logic                   pop          = 1'b0;
    logic                   kind;
    logic [OFFSET_BITS-1:0] word_offset;
    logic [7:0]             pixel_mask;
    logic [23:0]            colour;
    logic                   last;

    render_tracker trk;
    int            burst_left = 0;    // items left in the current sender burst
    int            items_sent = 0;    // input items accepted so far
    int            hold_at    = 0;    // item count that starts the long hold-off
    logic          hold       = 1'b0; // receiver held off while high
    int            rx_mode    = 0;
    int            rx_left    = 0;

    text_console_glyph_renderer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .char_code    (char_code),
        .font_is_bold (font_is_bold),
        .font_row     (font_row),
        .font_bits    (font_bits),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .word_offset  (word_offset),
        .pixel_mask   (pixel_mask),
        .colour       (colour),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item and hold it until the block takes it. Open a new burst
    // with a random gap first when the current one is used up; skip lowering
    // push when the gap is zero so push never drops and rises in one step.
    task automatic send_item(input logic c, input logic [7:0] ch, input logic fb,
                             input logic [3:0] fr, input logic [7:0] bits);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        push         <= 1'b1;
        cmd          <= c;
        char_code    <= ch;
        font_is_bold <= fb;
        font_row     <= fr;
        font_bits    <= bits;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // accepted at this edge: advance the mirror before the next item is picked
        trk.take_item(c, ch, fb, fr, bits);
        items_sent++;
        burst_left--;
    endtask

    // Load all lines of one glyph; ramp gives fixed extreme patterns
    task automatic load_glyph(input bit b, input logic [7:0] g, input bit ramp);
        logic [7:0] bits;
        for (int y = 0; y < LINES; y++)
        begin
            if (!ramp)
                bits = 8'($urandom_range(0, 255));
            else if (y == 0)
                bits = 8'hFF;
            else if (y == 1)
                bits = 8'h00;
            else
                bits = 8'h80 >> (y % 8);
            send_item(CMD_LOAD, g, b, 4'(y), bits);
        end
    endtask

    // Present one console character; load its glyph first when it would be
    // drawn from font lines that were never written.
    task automatic print_char(input logic [7:0] c);
        if (!trk.esc && c != CH_NEWLINE && c != CH_ESCAPE && !trk.glyph_ready(trk.bold, c))
            load_glyph(trk.bold, c, 1'b0);
        send_item(CMD_PRINT, c, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    // Drop push, wait for every owed result, then let the back end settle
    task automatic drain_idle();
        int n;
        push <= 1'b0;
        n = 0;
        while (trk.due_writes.size() != 0 && n < DRAIN_BOUND)
        begin
            @(posedge clk);
            n++;
        end
        repeat (IDLE_WAIT) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        trk.set_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [14:0] pw, input logic [7:0] tc,
                             input logic [6:0] tr, input logic pm);
        write_reg(REG_PITCH_WORDS, pw);
        write_reg(REG_TEXT_COLUMNS, {7'd0, tc});
        write_reg(REG_TEXT_ROWS, {8'd0, tr});
        write_reg(REG_PIXEL_MODE, {14'd0, pm});
    endtask

    // Random console traffic, mostly well-formed: printable text from a small
    // set of glyphs, newlines and escape sequences; the rest is stray font
    // loads and broken escapes.
    task automatic random_traffic(input int until_count);
        int         pick;
        logic [7:0] c;
        while (items_sent < until_count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 19) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'(8'h41 + $urandom_range(0, 3));
                print_char(c);
            end
            else if (pick < 65)
                print_char(CH_NEWLINE);
            else if (pick < 80)
            begin
                print_char(CH_ESCAPE);
                case ($urandom_range(0, 3))
                    0:       c = 8'($urandom_range(0, 15));
                    1:       c = CH_BOLD_OFF;
                    2:       c = CH_BOLD_ON;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                print_char(c);
            end
            else if (pick < 90)
                send_item(CMD_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            else
            begin
                // broken escape: newline or a second escape inside it, maybe unfinished
                print_char(CH_ESCAPE);
                print_char(($urandom_range(0, 1) == 0) ? CH_NEWLINE : CH_ESCAPE);
                if ($urandom_range(0, 1) == 0)
                    print_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: check each accepted result, then pick pop from a stall pattern
    // that is redrawn when its random run length is used up (always ready, coin flip, mostly stalled).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                trk.match_write({kind, word_offset, pixel_mask, colour, last});
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 200);
            end
            else
                rx_left--;
            case (rx_mode)
                0:       pop <= !hold;
                1:       pop <= !hold && ($urandom_range(0, 1) == 1);
                default: pop <= !hold && ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Long hold-off on the result side while the sender keeps offering items
    initial
    begin
        wait (hold_at != 0 && items_sent >= hold_at);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int          p;
        logic [14:0] pw;
        logic [7:0]  tc;
        logic [6:0]  tr;
        logic        pm;
        trk = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings. Glyph 0xFF gets full, empty and
        // single-pixel lines; glyph 0x00 and the bold font are loaded on demand.
        load_glyph(1'b0, 8'hFF, 1'b1);
        print_char(8'hFF);
        print_char(8'h00);
        print_char(CH_ESCAPE);
        print_char(8'h00);                // lowest colour
        print_char(8'hFF);
        print_char(CH_ESCAPE);
        print_char(CH_LAST_COLOUR);       // highest colour
        print_char(CH_ESCAPE);
        print_char(CH_BOLD_ON);
        print_char(8'hFF);                // drawn from the bold font
        print_char(CH_ESCAPE);
        print_char(CH_BOLD_OFF);
        print_char(CH_ESCAPE);
        print_char(8'h7F);                // code that only closes the escape
        print_char(8'hFF);
        // newline inside an escape runs and leaves it open; a second escape keeps it open
        print_char(CH_ESCAPE);
        print_char(CH_NEWLINE);
        print_char(CH_ESCAPE);
        print_char(8'h0C);
        print_char(8'hFF);
        print_char(CH_NEWLINE);
        drain_idle();

        // Register phases. Cursor state carries over, so shrinking the screen
        // after a roomy phase leaves the cursor past the last row and column.
        for (p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    pw = 15'd1;     tc = 8'd255; tr = 7'd127; pm = 1'b0;
                end
                1:
                begin
                    pw = 15'd16384; tc = 8'd1;   tr = 7'd1;   pm = MODE_16BPP;
                end
                2:
                begin
                    // zero columns and rows act as one
                    pw = 15'h7FFF;  tc = 8'd0;   tr = 7'd0;   pm = 1'b0;
                end
                5:
                begin
                    pw = 15'd16384; tc = 8'd255; tr = 7'd127; pm = MODE_16BPP;
                end
                default:
                begin
                    pw = 15'($urandom_range(1, 16384));
                    tc = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                                     : 8'($urandom_range(1, 255));
                    tr = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(1, 4))
                                                     : 7'($urandom_range(1, 127));
                    pm = 1'($urandom_range(0, 1));
                end
            endcase
            configure(pw, tc, tr, pm);
            if (p == 4)
                hold_at = items_sent + 10;
            case (p)
                0:       random_traffic(items_sent + 50);
                1:       random_traffic(items_sent + 30);
                2:       random_traffic(items_sent + 25);
                4:       random_traffic(items_sent + 80);
                6:       random_traffic((TOTAL_ITEMS > items_sent + 20) ? TOTAL_ITEMS
                                                                          : items_sent + 20);
                default: random_traffic(items_sent + 35);
            endcase
            drain_idle();
        end

        if (trk.due_writes.size() != 0)
        begin
            $error("%0d expected results never arrived", trk.due_writes.size());
            trk.errors++;
        end
        if (trk.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tcgr_pkg.sv
rtl/tcgr_fifo.sv
rtl/tcgr_front.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer_core.sv
tb/sv/text_console_glyph_renderer_core_tb.sv
